>>> rtl/hnsp_pkg.sv
// Package for the HEVC NAL stream probe: payload structs, command record,
// NAL kind codes and header constants. No dependencies.
`default_nettype none

package hnsp_pkg;

	localparam int POS_WIDTH_DEF   = 32;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam int NUM_KINDS       = 5;

	localparam logic [23:0] START_CODE    = 24'h000001;
	localparam logic [23:0] HISTORY_RESET = 24'hFFFFFF;
	localparam logic [7:0]  HDR1_BAD_MASK = 8'h81;	// forbidden bit and top layer-id bit
	localparam logic [7:0]  HDR2_BAD_MASK = 8'hF8;	// rest of layer id

	localparam logic [5:0] TYPE_SLICE_LAST = 6'd9;
	localparam logic [5:0] TYPE_IRAP_FIRST = 6'd16;
	localparam logic [5:0] TYPE_IRAP_LAST  = 6'd21;
	localparam logic [5:0] TYPE_VPS        = 6'd32;
	localparam logic [5:0] TYPE_SPS        = 6'd33;
	localparam logic [5:0] TYPE_PPS        = 6'd34;

	localparam logic REC_UNIT    = 1'b0;
	localparam logic REC_VERDICT = 1'b1;

	// which record of a command is on the result port
	localparam logic [1:0] SEL_UNIT    = 2'd0;
	localparam logic [1:0] SEL_FINAL   = 2'd1;
	localparam logic [1:0] SEL_VERDICT = 2'd2;

	typedef enum logic [2:0] {
		KIND_VPS   = 3'd0,
		KIND_SPS   = 3'd1,
		KIND_PPS   = 3'd2,
		KIND_IRAP  = 3'd3,
		KIND_SLICE = 3'd4,
		KIND_NONE  = 3'd5
	} nal_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} item_t;

	typedef struct packed {
		logic        record_kind;
		logic [15:0] nal_index;
		logic [31:0] nal_start;
		logic [31:0] nal_length;
		logic        stream_ok;
		logic [15:0] vps_seen;
		logic [15:0] sps_seen;
		logic [15:0] pps_seen;
		logic [15:0] irap_seen;
		logic [15:0] slice_seen;
		logic        final_item;
	} result_t;

	// Work left for the back end by one byte: an optional unit record and an
	// optional final record plus verdict.
	typedef struct packed {
		logic        has_unit;
		logic [15:0] unit_index;
		logic [31:0] unit_start;
		logic [31:0] unit_length;
		logic        has_final;
		logic [15:0] final_index;
		logic [31:0] final_start;
		logic [31:0] final_length;
		logic        stream_ok;
		logic [15:0] vps_seen;
		logic [15:0] sps_seen;
		logic [15:0] pps_seen;
		logic [15:0] irap_seen;
		logic [15:0] slice_seen;
	} cmd_t;

	function automatic nal_kind_t decode_kind(input logic [5:0] nal_type);
		nal_kind_t k;
		if (nal_type <= TYPE_SLICE_LAST)
			k = KIND_SLICE;
		else if (nal_type >= TYPE_IRAP_FIRST && nal_type <= TYPE_IRAP_LAST)
			k = KIND_IRAP;
		else if (nal_type == TYPE_VPS)
			k = KIND_VPS;
		else if (nal_type == TYPE_SPS)
			k = KIND_SPS;
		else if (nal_type == TYPE_PPS)
			k = KIND_PPS;
		else
			k = KIND_NONE;
		return k;
	endfunction

endpackage

`default_nettype wire

>>> rtl/hevc_nal_stream_probe.sv
// HEVC Annex B NAL stream probe, top level.
// The commands of a byte are registered in the command queue before the back end shows its results on the result port.
// Throughput: one byte per cycle while full is low; result records leave at one per cycle while pop is high, so a
// byte that yields two or three records holds the 4-entry command queue longer.
// Reset: arst_n clears history, positions, counters and queue; no clearing pass.
`default_nettype none

module hevc_nal_stream_probe #(
	parameter int POS_WIDTH   = hnsp_pkg::POS_WIDTH_DEF,
	parameter int COUNT_WIDTH = hnsp_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire hnsp_pkg::item_t item,
	output logic                 empty,
	input  wire logic            pop,
	output hnsp_pkg::result_t    result
);

	hnsp_pkg::cmd_t front_cmd, head_cmd;
	logic           cmd_push, head_valid, deq, accept;

	assign accept = push && !full;

	hnsp_front #(
		.POS_WIDTH   (POS_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.accept   (accept),
		.cmd      (front_cmd),
		.cmd_push (cmd_push)
	);

	hnsp_queue #(
		.DEPTH (hnsp_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_cmd     (front_cmd),
		.wr_en      (cmd_push),
		.full       (full),
		.head       (head_cmd),
		.head_valid (head_valid),
		.rd_en      (deq)
	);

	hnsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_cmd),
		.head_valid (head_valid),
		.deq        (deq),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

`ifndef SYNTH
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("queue full but no result shown");

	a_eos_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.end_of_stream) |=> !empty)
		else $error("end of stream transfer produced no result");

	a_verdict_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.record_kind == hnsp_pkg::REC_VERDICT) |-> result.final_item)
		else $error("verdict not marked as final record");

	a_unit_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.record_kind == hnsp_pkg::REC_UNIT) |-> !result.stream_ok)
		else $error("unit record carries a verdict");
`endif

endmodule

`default_nettype wire

>>> rtl/hnsp_front.sv
// Front end: start-code search, header checks, counters and unit tracking.
// Emits one command per byte that produces results. Depends on hnsp_pkg.
`default_nettype none

module hnsp_front #(
	parameter int POS_WIDTH   = hnsp_pkg::POS_WIDTH_DEF,
	parameter int COUNT_WIDTH = hnsp_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire hnsp_pkg::item_t item,
	input  wire logic           accept,
	output hnsp_pkg::cmd_t      cmd,
	output logic                cmd_push
);

	logic [23:0]            hist_q;
	logic                   pend_q;
	logic [5:0]             ptype_q;
	logic [POS_WIDTH-1:0]   ppos_q;
	logic [POS_WIDTH-1:0]   bpos_q;
	logic [POS_WIDTH-1:0]   ustart_q;
	logic [COUNT_WIDTH-1:0] uord_q;
	logic [COUNT_WIDTH-1:0] cnt_q [hnsp_pkg::NUM_KINDS];
	logic                   err_q;

	logic [7:0]             b;
	logic                   last;
	hnsp_pkg::nal_kind_t    kind;
	logic                   hdr2_ok, hdr2_bad, counted, boundary;
	logic                   hdr1, hdr1_bad, err_next, all_seen;
	logic [POS_WIDTH-1:0]   ustart_next, bpos_next;
	logic [COUNT_WIDTH-1:0] uord_next;
	logic [COUNT_WIDTH-1:0] cnt_next [hnsp_pkg::NUM_KINDS];

	function automatic logic [31:0] pos32(input logic [POS_WIDTH-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[31:0];
	endfunction

	function automatic logic [15:0] cnt16(input logic [COUNT_WIDTH-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[15:0];
	endfunction

	always_comb begin
		b        = item.data_byte;
		last     = item.end_of_stream;
		kind     = hnsp_pkg::decode_kind(ptype_q);
		hdr2_ok  = pend_q && !err_q && ((b & hnsp_pkg::HDR2_BAD_MASK) == 8'd0);
		hdr2_bad = pend_q && !err_q && ((b & hnsp_pkg::HDR2_BAD_MASK) != 8'd0);
		counted  = hdr2_ok && (kind != hnsp_pkg::KIND_NONE);
		boundary = counted && (kind != hnsp_pkg::KIND_VPS);
		// a first header byte on the final byte is ignored
		hdr1     = !pend_q && !err_q && (hist_q == hnsp_pkg::START_CODE) && !last;
		hdr1_bad = hdr1 && ((b & hnsp_pkg::HDR1_BAD_MASK) != 8'd0);
		err_next = err_q | hdr2_bad | hdr1_bad;

		for (int k = 0; k < hnsp_pkg::NUM_KINDS; k++) begin
			cnt_next[k] = cnt_q[k];
			if (counted && kind == hnsp_pkg::nal_kind_t'(3'(k)) && cnt_q[k] != '1)
				cnt_next[k] = cnt_q[k] + 1'b1;
		end

		ustart_next = counted ? ppos_q : ustart_q;
		uord_next   = (boundary && uord_q != '1) ? uord_q + 1'b1 : uord_q;
		bpos_next   = (bpos_q == '1) ? bpos_q : bpos_q + 1'b1;
		all_seen    = (cnt_next[hnsp_pkg::KIND_VPS] != '0) &&
		              (cnt_next[hnsp_pkg::KIND_SPS] != '0) &&
		              (cnt_next[hnsp_pkg::KIND_PPS] != '0) &&
		              (cnt_next[hnsp_pkg::KIND_IRAP] != '0);

		cmd.has_unit     = boundary;
		cmd.unit_index   = cnt16(uord_q);
		cmd.unit_start   = pos32(ustart_q);
		cmd.unit_length  = pos32(ppos_q - ustart_q);
		cmd.has_final    = last;
		cmd.final_index  = cnt16(uord_next);
		cmd.final_start  = pos32(ustart_next);
		cmd.final_length = pos32(bpos_q - ustart_next);
		cmd.stream_ok    = all_seen && !err_next;
		cmd.vps_seen     = cnt16(cnt_next[hnsp_pkg::KIND_VPS]);
		cmd.sps_seen     = cnt16(cnt_next[hnsp_pkg::KIND_SPS]);
		cmd.pps_seen     = cnt16(cnt_next[hnsp_pkg::KIND_PPS]);
		cmd.irap_seen    = cnt16(cnt_next[hnsp_pkg::KIND_IRAP]);
		cmd.slice_seen   = cnt16(cnt_next[hnsp_pkg::KIND_SLICE]);
		cmd_push         = accept && (boundary || last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q   <= hnsp_pkg::HISTORY_RESET;
			pend_q   <= 1'b0;
			ptype_q  <= '0;
			ppos_q   <= '0;
			bpos_q   <= '0;
			ustart_q <= '0;
			uord_q   <= '0;
			err_q    <= 1'b0;
			for (int k = 0; k < hnsp_pkg::NUM_KINDS; k++)
				cnt_q[k] <= '0;
		end else if (accept) begin
			if (last) begin
				// stream done: back to the reset state for the next one
				hist_q   <= hnsp_pkg::HISTORY_RESET;
				pend_q   <= 1'b0;
				bpos_q   <= '0;
				ustart_q <= '0;
				uord_q   <= '0;
				err_q    <= 1'b0;
				for (int k = 0; k < hnsp_pkg::NUM_KINDS; k++)
					cnt_q[k] <= '0;
			end else begin
				hist_q   <= {hist_q[15:0], b};
				pend_q   <= hdr1 && !hdr1_bad;
				bpos_q   <= bpos_next;
				ustart_q <= ustart_next;
				uord_q   <= uord_next;
				err_q    <= err_next;
				for (int k = 0; k < hnsp_pkg::NUM_KINDS; k++)
					cnt_q[k] <= cnt_next[k];
				if (hdr1) begin
					ptype_q <= b[6:1];	// nal_unit_type
					ppos_q  <= bpos_q;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/hnsp_queue.sv
// Short command queue between front and back end.
// Depends on hnsp_pkg for the command type.
`default_nettype none

module hnsp_queue #(
	parameter int DEPTH = hnsp_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire hnsp_pkg::cmd_t wr_cmd,
	input  wire logic           wr_en,
	output logic                full,
	output hnsp_pkg::cmd_t      head,
	output logic                head_valid,
	input  wire logic           rd_en
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hnsp_pkg::cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_wr      = wr_en && !full;
	assign do_rd      = rd_en && head_valid;

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> rtl/hnsp_back.sv
// Back end: expands the head command into one to three result records.
// Depends on hnsp_pkg.
`default_nettype none

module hnsp_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire hnsp_pkg::cmd_t head,
	input  wire logic           head_valid,
	output logic                deq,
	output hnsp_pkg::result_t   result,
	output logic                empty,
	input  wire logic           pop
);

	logic [1:0] sub_q;	// records of the head command already transferred
	logic [1:0] sel;
	logic       last_rec;

	always_comb begin
		// without a unit record the sequence starts at the final record
		sel      = sub_q + {1'b0, !head.has_unit};
		last_rec = head.has_final ? (sel == hnsp_pkg::SEL_VERDICT) : 1'b1;
		empty    = !head_valid;
		deq      = head_valid && pop && last_rec;

		result.vps_seen   = head.vps_seen;
		result.sps_seen   = head.sps_seen;
		result.pps_seen   = head.pps_seen;
		result.irap_seen  = head.irap_seen;
		result.slice_seen = head.slice_seen;
		result.final_item = last_rec;
		unique case (sel)
			hnsp_pkg::SEL_UNIT: begin
				result.record_kind = hnsp_pkg::REC_UNIT;
				result.nal_index   = head.unit_index;
				result.nal_start   = head.unit_start;
				result.nal_length  = head.unit_length;
				result.stream_ok   = 1'b0;
			end
			hnsp_pkg::SEL_FINAL: begin
				result.record_kind = hnsp_pkg::REC_UNIT;
				result.nal_index   = head.final_index;
				result.nal_start   = head.final_start;
				result.nal_length  = head.final_length;
				result.stream_ok   = 1'b0;
			end
			default: begin
				result.record_kind = hnsp_pkg::REC_VERDICT;
				result.nal_index   = '0;
				result.nal_start   = '0;
				result.nal_length  = '0;
				result.stream_ok   = head.stream_ok;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sub_q <= '0;
		else if (head_valid && pop)
			sub_q <= last_rec ? 2'd0 : sub_q + 2'd1;
	end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking bench for hevc_nal_stream_probe: byte stream in, NAL records out.
// Needs hnsp_pkg and the probe RTL; predicts every record and checks it on transfer.
module tb;
	import hnsp_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    pop = 1'b0;
	item_t   item = '0;
	logic    full;
	logic    empty;
	result_t result;

	hevc_nal_stream_probe u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial forever #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// idle rates in percent
	int send_idle_pct = 0;
	int pop_stall_pct = 0;
	int mismatches = 0;
	int bytes_sent = 0;

	result_t expected_records[$];

	// predicted probe state
	logic [23:0] prev_bytes;
	logic        hdr2_due;
	logic [5:0]  due_type;
	logic [31:0] due_pos;
	logic [31:0] byte_pos;
	logic [31:0] open_start;
	logic [15:0] open_index;
	logic [15:0] kind_count [NUM_KINDS];
	logic        hdr_error;

	function automatic void clear_probe_state();
		prev_bytes = HISTORY_RESET;
		hdr2_due   = 1'b0;
		due_type   = '0;
		due_pos    = '0;
		byte_pos   = '0;
		open_start = '0;
		open_index = '0;
		hdr_error  = 1'b0;
		foreach (kind_count[i])
			kind_count[i] = '0;
	endfunction

	function automatic logic [15:0] count_up(input logic [15:0] v);
		return (v == '1) ? v : v + 16'd1;
	endfunction

	function automatic result_t make_record(input logic kind, input logic [15:0] idx,
			input logic [31:0] start, input logic [31:0] len, input logic ok);
		result_t r;
		r.record_kind = kind;
		r.nal_index   = idx;
		r.nal_start   = start;
		r.nal_length  = len;
		r.stream_ok   = ok;
		r.vps_seen    = kind_count[KIND_VPS];
		r.sps_seen    = kind_count[KIND_SPS];
		r.pps_seen    = kind_count[KIND_PPS];
		r.irap_seen   = kind_count[KIND_IRAP];
		r.slice_seen  = kind_count[KIND_SLICE];
		r.final_item  = 1'b0;
		return r;
	endfunction

	function automatic void predict_nal_records(input item_t it);
		result_t     recs[$];
		logic [7:0]  b;
		logic        last;
		logic [31:0] here;
		nal_kind_t   k;
		logic        ok;
		b    = it.data_byte;
		last = it.end_of_stream;
		here = byte_pos;
		if (hdr2_due) begin
			hdr2_due = 1'b0;
			if (!hdr_error) begin
				if ((b & HDR2_BAD_MASK) != 0) begin
					hdr_error = 1'b1;
				end else begin
					if (due_type <= TYPE_SLICE_LAST)
						k = KIND_SLICE;
					else if (due_type >= TYPE_IRAP_FIRST && due_type <= TYPE_IRAP_LAST)
						k = KIND_IRAP;
					else if (due_type == TYPE_VPS)
						k = KIND_VPS;
					else if (due_type == TYPE_SPS)
						k = KIND_SPS;
					else if (due_type == TYPE_PPS)
						k = KIND_PPS;
					else
						k = KIND_NONE;
					if (k != KIND_NONE) begin
						kind_count[k] = count_up(kind_count[k]);
						// a VPS only moves the unit start, it does not close the unit
						if (k != KIND_VPS) begin
							recs.push_back(make_record(REC_UNIT, open_index, open_start,
								due_pos - open_start, 1'b0));
							open_index = count_up(open_index);
						end
						open_start = due_pos;
					end
				end
			end
		end else if (!hdr_error && prev_bytes == START_CODE && !last) begin
			if ((b & HDR1_BAD_MASK) != 0) begin
				hdr_error = 1'b1;
			end else begin
				hdr2_due = 1'b1;
				due_type = b[6:1];
				due_pos  = here;
			end
		end
		prev_bytes = {prev_bytes[15:0], b};
		byte_pos   = (here == '1) ? here : here + 32'd1;
		if (last) begin
			ok = !hdr_error && kind_count[KIND_VPS] != 0 && kind_count[KIND_SPS] != 0
				&& kind_count[KIND_PPS] != 0 && kind_count[KIND_IRAP] != 0;
			recs.push_back(make_record(REC_UNIT, open_index, open_start, here - open_start,
				1'b0));
			recs.push_back(make_record(REC_VERDICT, '0, '0, '0, ok));
			clear_probe_state();
		end
		if (recs.size() != 0)
			recs[recs.size() - 1].final_item = 1'b1;
		foreach (recs[i])
			expected_records.push_back(recs[i]);
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	// result side: random stalls on pop, check on every transfer
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_records.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected record: %0h", result);
			end else begin
				result_t want;
				want = expected_records.pop_front();
				compare_field("record_kind", want.record_kind, result.record_kind);
				compare_field("nal_index", want.nal_index, result.nal_index);
				compare_field("nal_start", want.nal_start, result.nal_start);
				compare_field("nal_length", want.nal_length, result.nal_length);
				compare_field("stream_ok", want.stream_ok, result.stream_ok);
				compare_field("vps_seen", want.vps_seen, result.vps_seen);
				compare_field("sps_seen", want.sps_seen, result.sps_seen);
				compare_field("pps_seen", want.pps_seen, result.pps_seen);
				compare_field("irap_seen", want.irap_seen, result.irap_seen);
				compare_field("slice_seen", want.slice_seen, result.slice_seen);
				compare_field("final_item", want.final_item, result.final_item);
			end
		end
		pop <= ($urandom_range(99) >= pop_stall_pct);
	end

	task automatic send_byte(input logic [7:0] b, input logic eos);
		item_t it;
		it.data_byte     = b;
		it.end_of_stream = eos;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		predict_nal_records(it);
		bytes_sent++;
	endtask

	task automatic send_sequence(input logic [7:0] seq [$]);
		foreach (seq[i])
			send_byte(seq[i], i == seq.size() - 1);
	endtask

	// hold off until the probe has handed over every record
	task automatic wait_drained();
		push <= 1'b0;
		do @(posedge clk); while (expected_records.size() != 0);
	endtask

	// mostly well-formed streams with random content, some noise and cut-off streams;
	// a stream is cut short where it would run past max_bytes
	task automatic send_random_stream(input int max_bytes);
		logic [7:0] bytes[$];
		logic [7:0] hdr1;
		logic [7:0] hdr2;
		logic [5:0] t;
		int         n_units;
		int         cut;
		int         r;
		if ($urandom_range(99) < 20) begin
			repeat ($urandom_range(1, 12)) begin
				r = $urandom_range(99);
				if (r < 50)
					bytes.push_back(8'h00);
				else if (r < 70)
					bytes.push_back(8'h01);
				else
					bytes.push_back(8'($urandom_range(255)));
			end
		end else begin
			n_units = $urandom_range(3, 8);
			for (int u = 0; u < n_units; u++) begin
				if (u < 4 && $urandom_range(99) < 70) begin
					case (u)
						0: t = TYPE_VPS;
						1: t = TYPE_SPS;
						2: t = TYPE_PPS;
						default: t = 6'($urandom_range(TYPE_IRAP_FIRST, TYPE_IRAP_LAST));
					endcase
				end else begin
					case ($urandom_range(9))
						0: t = TYPE_VPS;
						1: t = TYPE_SPS;
						2: t = TYPE_PPS;
						3, 4: t = 6'($urandom_range(TYPE_IRAP_FIRST, TYPE_IRAP_LAST));
						5, 6: t = 6'($urandom_range(0, TYPE_SLICE_LAST));
						7: t = 6'($urandom_range(10, 15));
						8: t = 6'($urandom_range(22, 31));
						default: t = 6'($urandom_range(35, 63));
					endcase
				end
				hdr1 = {1'b0, t, 1'b0};
				hdr2 = {5'd0, 3'($urandom_range(7))};
				r = $urandom_range(99);
				if (r < 3)
					hdr1[7] = 1'b1;
				else if (r < 6)
					hdr1[0] = 1'b1;
				else if (r < 9)
					hdr2[7:3] = 5'($urandom_range(1, 31));
				if ($urandom_range(3) == 0)
					bytes.push_back(8'h00);
				bytes.push_back(8'h00);
				bytes.push_back(8'h00);
				bytes.push_back(8'h01);
				bytes.push_back(hdr1);
				bytes.push_back(hdr2);
				repeat ($urandom_range(0, 6))
					bytes.push_back(8'($urandom_range(255)));
			end
		end
		cut = bytes.size();
		if ($urandom_range(99) < 20)
			cut = $urandom_range(1, bytes.size());
		if (cut > max_bytes)
			cut = max_bytes;
		for (int i = 0; i < cut; i++)
			send_byte(bytes[i], i == cut - 1);
	endtask

	task automatic run_streams(input int byte_budget);
		int stop_at;
		stop_at = bytes_sent + byte_budget;
		while (bytes_sent < stop_at)
			send_random_stream(stop_at - bytes_sent);
	endtask

	// VPS, SPS, PPS and an IDR; the stream ends on the IDR's second header byte
	task automatic test_full_stream();
		logic [7:0] s[$];
		send_idle_pct = 0;
		pop_stall_pct = 0;
		s = '{8'h00, 8'h00, 8'h01, {1'b0, TYPE_VPS, 1'b0}, 8'h01,
			8'h00, 8'h00, 8'h01, {1'b0, TYPE_SPS, 1'b0}, 8'h01,
			8'h00, 8'h00, 8'h01, {1'b0, TYPE_PPS, 1'b0}, 8'h01,
			8'h00, 8'h00, 8'h01, {1'b0, 6'd19, 1'b0}, 8'h01};
		send_sequence(s);
	endtask

	// a first header byte on the final byte is ignored, even with bad bits
	task automatic test_header_on_last_byte();
		logic [7:0] s[$];
		s = '{8'h00, 8'h00, 8'h01, 8'hFF};
		send_sequence(s);
	endtask

	// reserved bits in the second header byte, which is also the final byte
	task automatic test_second_byte_error();
		logic [7:0] s[$];
		s = '{8'h00, 8'h00, 8'h01, {1'b0, TYPE_VPS, 1'b0}, 8'hF8};
		send_sequence(s);
	endtask

	task automatic test_back_to_back();
		send_idle_pct = 0;
		pop_stall_pct = 0;
		run_streams(95);
	endtask

	task automatic test_sender_gaps();
		send_idle_pct = 70;
		pop_stall_pct = 0;
		run_streams(45);
		wait_drained();
		run_streams(45);
	endtask

	task automatic test_receiver_stalls();
		send_idle_pct = 0;
		pop_stall_pct = 70;
		run_streams(100);
	endtask

	task automatic test_both_idle();
		send_idle_pct = 25;
		pop_stall_pct = 25;
		run_streams(100);
	endtask

	initial begin
		clear_probe_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_full_stream();
		test_header_on_last_byte();
		test_second_byte_error();
		test_back_to_back();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		push <= 1'b0;
		do @(posedge clk); while (expected_records.size() != 0);
		repeat (5) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
